// ----- rtl/salru_pkg.sv -----
// Shared types and constants of the set-associative LRU cache tag model.
package salru_pkg;

  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;

  localparam int SETS    = 1 << MAX_SET_BITS;
  localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W  = $clog2(MAX_WAYS + 1);
  localparam int AGE_W   = WAY_W;
  localparam int AGE_MAX = MAX_WAYS - 1;

  localparam int ADDR_W = 64;
  localparam int TAG_W  = 64;
  localparam int CNT_W  = 32;

  localparam int SETB_W     = 3;
  localparam int BLKB_W     = 6;
  localparam int WAYSC_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam int IN_TDATA_W  = ADDR_W;
  localparam int IN_TUSER_W  = 2;
  localparam int OUTCOME_W   = 2;
  localparam int OUT_PAD_W   = (((OUTCOME_W + 3 * CNT_W + 7) / 8) * 8) - OUTCOME_W - 3 * CNT_W;
  localparam int OUT_TDATA_W = OUTCOME_W + 3 * CNT_W + OUT_PAD_W;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [IN_TUSER_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2,
    OP_IFETCH = 2'd3
  } opcode_e;

  typedef enum logic [OUTCOME_W-1:0] {
    OC_HIT   = 2'd0,
    OC_MISS  = 2'd1,
    OC_EVICT = 2'd2
  } outcome_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [SETB_W-1:0]  set_bits;
    logic [BLKB_W-1:0]  block_bits;
    logic [WAYSC_W-1:0] ways_in_use;
  } cfg_t;

  // One classified access waiting for the lookup engine.
  typedef struct packed {
    logic [SET_W-1:0]  set_idx;
    logic [TAG_W-1:0]  tag;
    logic              modify;
    logic [WCNT_W-1:0] ways;
  } req_t;

  // One set of the tag store.
  typedef struct packed {
    logic [MAX_WAYS-1:0]            valid;
    logic [MAX_WAYS-1:0][AGE_W-1:0] age;
    logic [MAX_WAYS-1:0][TAG_W-1:0] tag;
  } row_t;

endpackage

// ----- rtl/salru_front.sv -----
// Front end: accepts accesses, drops fetches and splits the address into set and tag.
module salru_front (
  input  salru_pkg::cfg_t                       cfg_i,
  input  logic                                  s_valid_i,
  output logic                                  s_ready_o,
  input  logic [salru_pkg::IN_TDATA_W-1:0]      s_data_i,
  input  logic [salru_pkg::IN_TUSER_W-1:0]      s_user_i,
  output logic                                  push_o,
  output salru_pkg::req_t                       push_req_o,
  input  logic                                  full_i
);
  import salru_pkg::*;

  logic [SETB_W-1:0] sb;
  logic [BLKB_W:0]   shift_total;
  logic [ADDR_W-1:0] shifted;
  logic [SET_W-1:0]  set_mask;
  logic [WCNT_W-1:0] ways;
  logic              is_fetch;

  assign sb = (int'(cfg_i.set_bits) > MAX_SET_BITS) ? SETB_W'(MAX_SET_BITS) : cfg_i.set_bits;

  assign shifted     = s_data_i >> cfg_i.block_bits;
  assign set_mask    = ~({SET_W{1'b1}} << sb);
  assign shift_total = {1'b0, cfg_i.block_bits} + (BLKB_W + 1)'(sb);

  always_comb begin
    if (cfg_i.ways_in_use == '0) begin
      ways = WCNT_W'(1);
    end else if (int'(cfg_i.ways_in_use) > MAX_WAYS) begin
      ways = WCNT_W'(MAX_WAYS);
    end else begin
      ways = WCNT_W'(cfg_i.ways_in_use);
    end
  end

  always_comb begin
    push_req_o.set_idx = shifted[SET_W-1:0] & set_mask;
    // Offset plus index bits that cover the whole address leave a zero tag.
    push_req_o.tag     = (shift_total >= (BLKB_W + 1)'(ADDR_W)) ? '0
                                                                 : s_data_i >> shift_total;
    push_req_o.modify  = (opcode_e'(s_user_i) == OP_MODIFY);
    push_req_o.ways    = ways;
  end

  assign is_fetch  = (opcode_e'(s_user_i) == OP_IFETCH);
  assign s_ready_o = !full_i;
  assign push_o    = s_valid_i && !full_i && !is_fetch;

endmodule

// ----- rtl/salru_queue.sv -----
// Short request queue between the front end and the lookup engine.
module salru_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  salru_pkg::req_t push_req_i,
  output logic            full_o,
  input  logic            pop_i,
  output salru_pkg::req_t head_o,
  output logic            empty_o
);
  import salru_pkg::*;

  req_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule

// ----- rtl/salru_back.sv -----
// Lookup engine: reads a set, updates tags and ages, counts and issues results.
module salru_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 q_empty_i,
  input  salru_pkg::req_t                      q_head_i,
  output logic                                 pop_o,
  output logic                                 m_valid_o,
  input  logic                                 m_ready_i,
  output logic [salru_pkg::OUT_TDATA_W-1:0]    m_data_o,
  output logic                                 m_last_o
);
  import salru_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_EVAL   = 3'b010,
    ST_SECOND = 3'b100
  } state_e;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  state_e state_q, state_d;

  row_t            mem_q [SETS];
  row_t            rd_row_q;
  logic            rd_rowv_q;
  logic [SETS-1:0] rowv_q;
  req_t            cur_q;

  logic [CNT_W-1:0] hits_q, hits_d;
  logic [CNT_W-1:0] miss_q, miss_d;
  logic [CNT_W-1:0] evict_q, evict_d;

  logic     out_valid_q, out_valid_d;
  outcome_e out_outcome_q, out_outcome_d;
  logic     out_last_q, out_last_d;

  logic     out_free;
  logic     advance;
  logic     wr_en;

  row_t                cur_row;
  row_t                new_row;
  logic [MAX_WAYS-1:0] in_range;
  logic                hit_found;
  logic [WAY_W-1:0]    hit_idx;
  logic                inv_found;
  logic [WAY_W-1:0]    inv_idx;
  logic [WAY_W-1:0]    vic_idx;
  logic [AGE_W-1:0]    vic_age;
  logic [WAY_W-1:0]    tgt;
  outcome_e            pass_outcome;

  // A set that was never written reads as all lines invalid with age zero.
  always_comb begin
    cur_row.valid = rd_rowv_q ? rd_row_q.valid : '0;
    cur_row.age   = rd_rowv_q ? rd_row_q.age : '0;
    cur_row.tag   = rd_row_q.tag;
  end

  always_comb begin
    in_range  = '0;
    hit_found = 1'b0;
    hit_idx   = '0;
    inv_found = 1'b0;
    inv_idx   = '0;
    vic_idx   = '0;
    vic_age   = cur_row.age[0];
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_range[w] = (WCNT_W'(w) < cur_q.ways);
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (!hit_found && in_range[w] && cur_row.valid[w] && (cur_row.tag[w] == cur_q.tag)) begin
        hit_found = 1'b1;
        hit_idx   = WAY_W'(w);
      end
      if (!inv_found && in_range[w] && !cur_row.valid[w]) begin
        inv_found = 1'b1;
        inv_idx   = WAY_W'(w);
      end
    end
    // Strictly greater keeps the lowest-numbered way among equal oldest ages.
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (in_range[w] && (cur_row.age[w] > vic_age)) begin
        vic_idx = WAY_W'(w);
        vic_age = cur_row.age[w];
      end
    end
  end

  always_comb begin
    new_row = cur_row;
    if (hit_found) begin
      tgt          = hit_idx;
      pass_outcome = OC_HIT;
    end else if (inv_found) begin
      tgt          = inv_idx;
      pass_outcome = OC_MISS;
    end else begin
      tgt          = vic_idx;
      pass_outcome = OC_EVICT;
    end
    for (int j = 0; j < MAX_WAYS; j++) begin
      if ((WAY_W'(j) != tgt) && in_range[j] && cur_row.valid[j] &&
          (cur_row.age[j] < AGE_W'(AGE_MAX)) &&
          (inv_found && !hit_found || cur_row.age[j] < cur_row.age[tgt])) begin
        new_row.age[j] = cur_row.age[j] + 1'b1;
      end
    end
    new_row.valid[tgt] = 1'b1;
    new_row.age[tgt]   = '0;
    new_row.tag[tgt]   = cur_q.tag;
  end

  assign out_free = !out_valid_q || m_ready_i;

  always_comb begin
    state_d       = state_q;
    pop_o         = 1'b0;
    advance       = 1'b0;
    wr_en         = 1'b0;
    hits_d        = hits_q;
    miss_d        = miss_q;
    evict_d       = evict_q;
    out_outcome_d = out_outcome_q;
    out_last_d    = out_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (out_free) begin
          advance       = 1'b1;
          wr_en         = 1'b1;
          out_outcome_d = pass_outcome;
          out_last_d    = !cur_q.modify;
          if (pass_outcome == OC_HIT) begin
            hits_d = sat_inc(hits_q);
          end else begin
            miss_d = sat_inc(miss_q);
          end
          if (pass_outcome == OC_EVICT) begin
            evict_d = sat_inc(evict_q);
          end
          state_d = cur_q.modify ? ST_SECOND : ST_IDLE;
        end
      end
      ST_SECOND: begin
        // The line was just installed or refreshed, so the second pass always hits.
        if (out_free) begin
          advance       = 1'b1;
          out_outcome_d = OC_HIT;
          out_last_d    = 1'b1;
          hits_d        = sat_inc(hits_q);
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rowv_q      <= '0;
      rd_rowv_q   <= 1'b0;
      hits_q      <= '0;
      miss_q      <= '0;
      evict_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hits_q      <= hits_d;
      miss_q      <= miss_d;
      evict_q     <= evict_d;
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        rd_rowv_q <= rowv_q[q_head_i.set_idx];
      end
      if (wr_en) begin
        rowv_q[cur_q.set_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd_row_q <= mem_q[q_head_i.set_idx];
      cur_q    <= q_head_i;
    end
    if (wr_en) begin
      mem_q[cur_q.set_idx] <= new_row;
    end
    out_outcome_q <= out_outcome_d;
    out_last_q    <= out_last_d;
  end

  // The totals only move when a new result is loaded, so they match the held result.
  assign m_valid_o = out_valid_q;
  assign m_last_o  = out_last_q;
  assign m_data_o  = {{OUT_PAD_W{1'b0}}, evict_q, miss_q, hits_q, out_outcome_q};

`ifndef ASSERT_OFF
  a_second_is_modify: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SECOND) |-> cur_q.modify)
    else $error("second pass without a modify access");

  a_first_of_two_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SECOND && out_valid_q) |-> !out_last_q)
    else $error("first result of a modify marked as last");

  a_evict_le_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evict_q <= miss_q)
    else $error("eviction total exceeds miss total");

  a_hits_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (hits_q >= $past(hits_q)))
    else $error("hit total decreased");
`endif

endmodule

// ----- rtl/set_assoc_cache_lru_sim_unit.sv -----
// Top level of the set-associative LRU cache tag model: configuration and wiring.
// A load or store passes the lookup engine as a set read, then an update and write back;
// a modify adds a second pass; fetches take no engine time. The next access is read only
// once the last is through, and the update waits while a result is held. The request
// queue holds two accesses, so the input keeps moving while results stall until it is full.
// Reset is asynchronous and active low; per-set valid flops clear the tag store at once.
module set_assoc_cache_lru_sim_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [salru_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [salru_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // address [63:0]
  input  logic [salru_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // opcode [1:0]
  input  logic [salru_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // outcome [1:0], hit_total [33:2], miss_total [65:34], eviction_total [97:66], zero pad
  output logic [salru_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                              m_axis_tlast
);
  import salru_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic push;
  req_t push_req;
  logic q_full;
  logic pop;
  req_t q_head;
  logic q_empty;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SET_BITS:   cfg_d.set_bits    = cfg_data_i[SETB_W-1:0];
        CFG_BLOCK_BITS: cfg_d.block_bits  = cfg_data_i[BLKB_W-1:0];
        CFG_WAYS:       cfg_d.ways_in_use = cfg_data_i[WAYSC_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.set_bits    <= '0;
      cfg_q.block_bits  <= '0;
      cfg_q.ways_in_use <= WAYSC_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  salru_front u_front (
    .cfg_i      (cfg_q),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .s_data_i   (s_axis_tdata),
    .s_user_i   (s_axis_tuser),
    .push_o     (push),
    .push_req_o (push_req),
    .full_i     (q_full)
  );

  salru_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_req_i (push_req),
    .full_o     (q_full),
    .pop_i      (pop),
    .head_o     (q_head),
    .empty_o    (q_empty)
  );

  salru_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_head_i   (q_head),
    .pop_o      (pop),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata),
    .m_last_o   (m_axis_tlast)
  );

endmodule

// ----- tb/set_assoc_cache_lru_sim_unit_tb.sv -----
// Self-checking testbench for the set-associative LRU cache tag model.
module set_assoc_cache_lru_sim_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import salru_pkg::*;

  localparam int LINES  = SETS * MAX_WAYS;
  localparam int PHASES = 11;

  typedef struct {
    opcode_e           op;
    logic [ADDR_W-1:0] addr;
  } access_t;

  typedef struct {
    outcome_e         outcome;
    logic             last;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] evict_total;
  } lookup_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_axis_tready;
  // address [63:0]
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  // opcode [1:0]
  logic [IN_TUSER_W-1:0]  s_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_ready = 1'b0;
  // outcome [1:0], hit_total [33:2], miss_total [65:34], eviction_total [97:66], zero pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  // Shadow copy of the tag store, counters and configuration.
  bit                 line_valid [LINES];
  logic [TAG_W-1:0]   line_tag [LINES];
  bit   [AGE_W-1:0]   line_age [LINES];
  logic [CNT_W-1:0]   hit_tally = '0;
  logic [CNT_W-1:0]   miss_tally = '0;
  logic [CNT_W-1:0]   evict_count = '0;
  bit   [SETB_W-1:0]  cfg_set_bits = '0;
  bit   [BLKB_W-1:0]  cfg_block_bits = '0;
  bit   [WAYSC_W-1:0] cfg_ways = 4'd1;

  access_t        access_q [$];
  lookup_result_t lookup_results_q [$];
  int unsigned    mismatches = 0;
  bit             calm = 1'b0;
  int unsigned    src_idle = 0;
  int unsigned    sink_idle = 0;

  set_assoc_cache_lru_sim_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void age_up(int i);
    if (line_age[i] < AGE_W'(AGE_MAX)) line_age[i] = line_age[i] + 1'b1;
  endfunction

  // One pass through the set starting at line base.
  function automatic outcome_e cache_lookup(int base, int ways, logic [TAG_W-1:0] tag);
    int           victim;
    bit [AGE_W-1:0] a;
    for (int w = 0; w < ways; w++) begin
      if (line_valid[base+w] && line_tag[base+w] == tag) begin
        a = line_age[base+w];
        for (int k = 0; k < ways; k++)
          if (k != w && line_valid[base+k] && line_age[base+k] < a) age_up(base + k);
        line_age[base+w] = '0;
        hit_tally = bump(hit_tally);
        return OC_HIT;
      end
    end
    for (int w = 0; w < ways; w++) begin
      if (!line_valid[base+w]) begin
        for (int k = 0; k < ways; k++)
          if (line_valid[base+k]) age_up(base + k);
        line_valid[base+w] = 1'b1;
        line_tag[base+w]   = tag;
        line_age[base+w]   = '0;
        miss_tally = bump(miss_tally);
        return OC_MISS;
      end
    end
    // Oldest way goes; on a tie the lowest-numbered one.
    victim = base;
    for (int k = 1; k < ways; k++)
      if (line_age[base+k] > line_age[victim]) victim = base + k;
    a = line_age[victim];
    for (int k = 0; k < ways; k++)
      if (base + k != victim && line_age[base+k] < a) age_up(base + k);
    line_tag[victim] = tag;
    line_age[victim] = '0;
    miss_tally  = bump(miss_tally);
    evict_count = bump(evict_count);
    return OC_EVICT;
  endfunction

  function automatic void predict_access(opcode_e op, logic [ADDR_W-1:0] addr);
    int               sb;
    int               ways;
    int               set_idx;
    int               passes;
    logic [TAG_W-1:0] tag;
    lookup_result_t   r;
    if (op == OP_IFETCH) return;
    sb   = (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(cfg_set_bits);
    ways = int'(cfg_ways);
    if (ways < 1) ways = 1;
    if (ways > MAX_WAYS) ways = MAX_WAYS;
    set_idx = int'((addr >> cfg_block_bits) & ((64'd1 << sb) - 64'd1));
    tag     = addr >> (int'(cfg_block_bits) + sb);
    passes  = (op == OP_MODIFY) ? 2 : 1;
    for (int p = 0; p < passes; p++) begin
      r.outcome     = cache_lookup(set_idx * MAX_WAYS, ways, tag);
      r.last        = (p + 1 == passes);
      r.hit_total   = hit_tally;
      r.miss_total  = miss_tally;
      r.evict_total = evict_count;
      lookup_results_q.push_back(r);
    end
  endfunction

  // Sender: the expectation is formed at the edge where the item is taken.
  always @(posedge clk_i) begin : drive
    access_t nxt;
    if (rst_ni) begin
      if (s_tvalid && s_axis_tready) predict_access(opcode_e'(s_tuser), s_tdata);
      if (!s_tvalid || s_axis_tready) begin
        if (src_idle > 0) begin
          src_idle--;
          s_tvalid <= 1'b0;
        end else if (access_q.size() > 0) begin
          nxt = access_q.pop_front();
          s_tdata  <= nxt.addr;
          s_tuser  <= nxt.op;
          s_tvalid <= 1'b1;
          if (!calm && $urandom_range(0, 7) == 0) src_idle = $urandom_range(1, 10);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall bursts and field-by-field comparison.
  always @(posedge clk_i) begin : watch
    lookup_result_t exp_r;
    if (rst_ni) begin
      if (m_axis_tvalid && m_ready) begin
        if (lookup_results_q.size() == 0) begin
          $error("unexpected result: outcome %0d", m_axis_tdata[1:0]);
          mismatches++;
        end else begin
          exp_r = lookup_results_q.pop_front();
          if (m_axis_tdata[1:0] !== exp_r.outcome) begin
            $error("outcome: expected %0d, got %0d", exp_r.outcome, m_axis_tdata[1:0]);
            mismatches++;
          end
          if (m_axis_tlast !== exp_r.last) begin
            $error("last: expected %0d, got %0d", exp_r.last, m_axis_tlast);
            mismatches++;
          end
          if (m_axis_tdata[33:2] !== exp_r.hit_total) begin
            $error("hit_total: expected %0d, got %0d", exp_r.hit_total, m_axis_tdata[33:2]);
            mismatches++;
          end
          if (m_axis_tdata[65:34] !== exp_r.miss_total) begin
            $error("miss_total: expected %0d, got %0d", exp_r.miss_total,
                   m_axis_tdata[65:34]);
            mismatches++;
          end
          if (m_axis_tdata[97:66] !== exp_r.evict_total) begin
            $error("eviction_total: expected %0d, got %0d", exp_r.evict_total,
                   m_axis_tdata[97:66]);
            mismatches++;
          end
        end
      end
      if (sink_idle > 0) begin
        sink_idle--;
        m_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        sink_idle = $urandom_range(0, 9);
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  task automatic write_config(bit [SETB_W-1:0] sb, bit [BLKB_W-1:0] bb,
                              bit [WAYSC_W-1:0] ways);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_SET_BITS;
    cfg_data <= CFG_DATA_W'(sb);
    @(posedge clk_i);
    cfg_idx  <= CFG_BLOCK_BITS;
    cfg_data <= CFG_DATA_W'(bb);
    @(posedge clk_i);
    cfg_idx  <= CFG_WAYS;
    cfg_data <= CFG_DATA_W'(ways);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cfg_set_bits   = sb;
    cfg_block_bits = bb;
    cfg_ways       = ways;
  endtask

  // Blocks until the sender is drained and every result has come back.
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (access_q.size() != 0 || s_tvalid || lookup_results_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic void queue_access(opcode_e op, logic [ADDR_W-1:0] addr);
    access_t a;
    a.op   = op;
    a.addr = addr;
    access_q.push_back(a);
  endfunction

  // Address for the directed part: 4 sets, 16-byte blocks.
  function automatic logic [ADDR_W-1:0] slot(int tag, int set_idx, int offs);
    return (ADDR_W'(tag) << 6) | (ADDR_W'(set_idx) << 4) | ADDR_W'(offs);
  endfunction

  initial begin
    bit [SETB_W-1:0]   ph_sb   [PHASES] = '{3, 0, 6, 7, 1, 2, 6, 4, 5, 3, 2};
    bit [BLKB_W-1:0]   ph_bb   [PHASES] = '{5, 0, 6, 3, 32, 2, 63, 58, 0, 6, 4};
    bit [WAYSC_W-1:0]  ph_ways [PHASES] = '{4, 1, 8, 8, 0, 15, 3, 5, 8, 6, 4};
    logic [TAG_W-1:0]  tag_pool [$];
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] set_pick;
    logic [ADDR_W-1:0] offs;
    opcode_e           op;
    int                sb_eff;
    int                ways_eff;
    int                bb;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_config(3'd2, 6'd4, 4'd2);
    queue_access(OP_LOAD,   slot(1, 0, 0));
    queue_access(OP_LOAD,   slot(1, 0, 15));
    queue_access(OP_STORE,  slot(2, 0, 3));
    queue_access(OP_MODIFY, slot(3, 0, 0));
    queue_access(OP_IFETCH, slot(1, 0, 0));
    queue_access(OP_LOAD,   slot(1, 0, 0));
    queue_access(OP_LOAD,   64'd0);
    queue_access(OP_STORE,  '1);
    queue_access(OP_MODIFY, '1);
    queue_access(OP_IFETCH, 64'd0);
    queue_access(OP_LOAD,   slot(5, 3, 7));
    queue_access(OP_LOAD,   slot(6, 3, 7));
    queue_access(OP_LOAD,   slot(5, 3, 7));
    queue_access(OP_STORE,  slot(7, 3, 0));
    queue_access(OP_MODIFY, slot(6, 3, 0));
    queue_access(OP_LOAD,   64'h8000_0000_0000_0000);
    queue_access(OP_LOAD,   64'h5555_5555_5555_5555);
    queue_access(OP_STORE,  64'hAAAA_AAAA_AAAA_AAAA);
    queue_access(OP_MODIFY, slot(2, 1, 0));
    queue_access(OP_IFETCH, '1);

    for (int p = 0; p < PHASES; p++) begin
      wait_quiet();
      if (p == PHASES - 1) calm = 1'b1;
      write_config(ph_sb[p], ph_bb[p], ph_ways[p]);
      sb_eff   = (ph_sb[p] > MAX_SET_BITS) ? MAX_SET_BITS : int'(ph_sb[p]);
      ways_eff = (ph_ways[p] == 0) ? 1 : (ph_ways[p] > MAX_WAYS) ? MAX_WAYS : int'(ph_ways[p]);
      bb       = int'(ph_bb[p]);
      // A few more tags than ways, so sets see hits, fills and evictions.
      tag_pool.delete();
      for (int t = 0; t < ways_eff + 2; t++)
        tag_pool.push_back(t[0] ? {$urandom, $urandom} : TAG_W'($urandom_range(0, 15)));
      for (int n = 0; n < 58; n++) begin
        case ($urandom_range(0, 15))
          0, 1, 2, 3, 4, 5: op = OP_LOAD;
          6, 7, 8, 9:       op = OP_STORE;
          10, 11, 12, 13:   op = OP_MODIFY;
          default:          op = OP_IFETCH;
        endcase
        if ($urandom_range(0, 9) == 0) begin
          addr = {$urandom, $urandom};
        end else begin
          set_pick = ($urandom_range(0, 3) == 0) ? ADDR_W'($urandom)
                                                 : ADDR_W'($urandom_range(0, 3));
          offs = {$urandom, $urandom};
          addr = (tag_pool[$urandom_range(0, tag_pool.size() - 1)] << (bb + sb_eff))
               | ((set_pick & ((64'd1 << sb_eff) - 64'd1)) << bb)
               | (offs & ((64'd1 << bb) - 64'd1));
        end
        queue_access(op, addr);
      end
    end

    wait_quiet();
    repeat (20) @(posedge clk_i);
    if (lookup_results_q.size() != 0) begin
      $error("%0d results never arrived", lookup_results_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/salru_pkg.sv
rtl/salru_front.sv
rtl/salru_queue.sv
rtl/salru_back.sv
rtl/set_assoc_cache_lru_sim_unit.sv
tb/set_assoc_cache_lru_sim_unit_tb.sv
